// File: rtl/core/epds_pkg.sv
// ----------------------------------------------------------------------------
// epds_pkg: shared types and constants of the earliest-due poll scheduler
// Word formats, operation codes, slot entry layout and sizing constants.
// ----------------------------------------------------------------------------
package epds_pkg;

	// Sizing of the slot store.
	localparam int MAX_SLOTS  = 64;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

	// Field widths fixed by the interface.
	localparam int TIME_W     = 48;
	localparam int PERIOD_W   = 16;
	localparam int STREAK_W   = 3;
	localparam int FCOUNT_W   = 7;
	localparam int WAIT_W     = 10;

	// Caps on wait, back-off delay and failure streak.
	localparam int WAIT_CAP   = 1000;
	localparam int DELAY_CAP  = 30000;
	localparam int STREAK_CAP = 5;
	localparam int DELAY_W    = $clog2(DELAY_CAP + 1);
	localparam int SHIFT_W    = PERIOD_W + (1 << STREAK_W) - 1;

	// Operation codes of an input word.
	typedef enum logic [1:0] {
		OP_SELECT = 2'd0,
		OP_REPORT = 2'd1,
		OP_START  = 2'd2,
		OP_STOP   = 2'd3
	} op_e;

	// Result kinds.
	localparam logic KIND_ISSUE = 1'b0;
	localparam logic KIND_WAIT  = 1'b1;

	typedef struct packed {
		op_e                 operation;
		logic [TIME_W-1:0]   now_ms;
		logic [5:0]          slot_index;
		logic                succeeded;
		logic [PERIOD_W-1:0] period_ms;
	} req_t;

	typedef struct packed {
		logic              kind;
		logic [5:0]        chosen_slot;
		logic [WAIT_W-1:0] wait_ms;
	} rsp_t;

	// One entry of the slot RAM.
	typedef struct packed {
		logic [TIME_W-1:0]   due_time;
		logic [STREAK_W-1:0] streak;
	} slot_ent_t;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_DIFF,
		ST_FINISH,
		ST_RPT_RD,
		ST_RPT_DLY,
		ST_RPT_WR
	} st_e;

endpackage

// File: rtl/core/epds_ram.sv
// ----------------------------------------------------------------------------
// epds_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module epds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/epds_engine.sv
// ----------------------------------------------------------------------------
// epds_engine: scan and update sequencer of the poll scheduler
// Runs select scans and report updates against the slot RAM, one word at a
// time, and keeps the running flag, the saved next slot and entry valid bits.
// ----------------------------------------------------------------------------
module epds_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  epds_pkg::req_t               req,
	input  logic [epds_pkg::CNT_W-1:0]   slot_cnt,
	output logic                         res_valid,
	output epds_pkg::rsp_t               res,
	input  logic                         res_taken
);

	epds_pkg::st_e st_q, st_d;

	logic                              running_q;
	logic [epds_pkg::SLOT_W-1:0]       next_slot_q;
	logic [epds_pkg::MAX_SLOTS-1:0]    valid_q;
	logic                              live_s1;

	epds_pkg::req_t                    req_q;
	logic [epds_pkg::SLOT_W-1:0]       idx_q;
	logic [epds_pkg::CNT_W-1:0]        remain_q;
	logic                              rd_vld_s1;
	logic [epds_pkg::SLOT_W-1:0]       rd_idx_s1;
	logic                              first_s1;
	logic [epds_pkg::TIME_W-1:0]       best_due_q;
	logic [epds_pkg::SLOT_W-1:0]       best_q;
	logic [epds_pkg::TIME_W-1:0]       diff_q;
	logic                              late_q;
	logic [epds_pkg::STREAK_W-1:0]     streak_q;
	logic [epds_pkg::DELAY_W-1:0]      delay_q;

	logic                              accept;
	logic                              active;
	logic                              rpt_ok;
	logic                              issue;
	logic                              we;
	logic [epds_pkg::SLOT_W-1:0]       raddr;
	logic [epds_pkg::SLOT_W-1:0]       rpt_slot;
	epds_pkg::slot_ent_t               rdata;
	epds_pkg::slot_ent_t               wdata;
	logic [epds_pkg::CNT_W-1:0]        idx_ext;
	logic [epds_pkg::CNT_W-1:0]        idx_inc;
	logic [epds_pkg::SLOT_W-1:0]       idx_next;
	logic [epds_pkg::CNT_W-1:0]        best_inc;
	logic [epds_pkg::SLOT_W-1:0]       best_next;
	logic [epds_pkg::TIME_W-1:0]       cur_due;
	logic [epds_pkg::TIME_W:0]         diff_full;
	logic [epds_pkg::STREAK_W-1:0]     old_streak;
	logic [epds_pkg::STREAK_W-1:0]     new_streak;
	logic [epds_pkg::PERIOD_W-1:0]     period_eff;
	logic [epds_pkg::SHIFT_W-1:0]      shifted;
	logic [epds_pkg::DELAY_W-1:0]      delay_cap;

	// Slot RAM holding due time and failure streak of each slot.
	epds_ram #(
		.WIDTH($bits(epds_pkg::slot_ent_t)),
		.DEPTH(epds_pkg::MAX_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (we),
		.waddr(rpt_slot),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Handshake qualifiers.
	assign accept   = req_valid && !req_stall;
	assign active   = running_q && (slot_cnt != '0);
	assign rpt_ok   = active && (epds_pkg::CNT_W'(req.slot_index) < slot_cnt);
	assign rpt_slot = epds_pkg::SLOT_W'(req_q.slot_index);

	// Rotation helpers: step an index and wrap at the slot count.
	assign idx_ext   = epds_pkg::CNT_W'(idx_q);
	assign idx_inc   = idx_ext + epds_pkg::CNT_W'(1);
	assign idx_next  = (idx_inc == slot_cnt) ? '0 : epds_pkg::SLOT_W'(idx_inc);
	assign best_inc  = epds_pkg::CNT_W'(best_q) + epds_pkg::CNT_W'(1);
	assign best_next = (best_inc == slot_cnt) ? '0 : epds_pkg::SLOT_W'(best_inc);

	// An entry that was never written since start reads as zero.
	assign cur_due = rd_vld_s1 ? rdata.due_time : '0;

	// One subtraction gives both the distance and whether the slot is not yet due.
	assign diff_full = {1'b0, best_due_q} - {1'b0, req_q.now_ms};

	// Back-off: new streak, period shifted by it, capped delay.
	assign old_streak = rd_vld_s1 ? rdata.streak : '0;
	always_comb begin
		if (req_q.succeeded) begin
			new_streak = '0;
		end else if (old_streak < epds_pkg::STREAK_W'(epds_pkg::STREAK_CAP)) begin
			new_streak = old_streak + epds_pkg::STREAK_W'(1);
		end else begin
			new_streak = old_streak;
		end
	end
	assign period_eff = (req_q.period_ms == '0) ? epds_pkg::PERIOD_W'(1) : req_q.period_ms;
	assign shifted    = epds_pkg::SHIFT_W'(period_eff) << new_streak;
	assign delay_cap  = (shifted > epds_pkg::SHIFT_W'(epds_pkg::DELAY_CAP)) ?
		epds_pkg::DELAY_W'(epds_pkg::DELAY_CAP) : epds_pkg::DELAY_W'(shifted);

	assign wdata.due_time = req_q.now_ms + epds_pkg::TIME_W'(delay_q);
	assign wdata.streak   = streak_q;

	// Next-state logic.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			epds_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.operation)
						epds_pkg::OP_SELECT: st_d = active ? epds_pkg::ST_MOD : epds_pkg::ST_IDLE;
						epds_pkg::OP_REPORT: st_d = rpt_ok ? epds_pkg::ST_RPT_RD : epds_pkg::ST_IDLE;
						epds_pkg::OP_START,
						epds_pkg::OP_STOP:   st_d = epds_pkg::ST_IDLE;
					endcase
				end
			end
			epds_pkg::ST_MOD: begin
				if (idx_ext < slot_cnt) begin
					st_d = epds_pkg::ST_SCAN;
				end
			end
			epds_pkg::ST_SCAN: begin
				if (remain_q == '0 && !live_s1) begin
					st_d = epds_pkg::ST_DIFF;
				end
			end
			epds_pkg::ST_DIFF:    st_d = epds_pkg::ST_FINISH;
			epds_pkg::ST_FINISH: begin
				if (res_taken) begin
					st_d = epds_pkg::ST_IDLE;
				end
			end
			epds_pkg::ST_RPT_RD:  st_d = epds_pkg::ST_RPT_DLY;
			epds_pkg::ST_RPT_DLY: st_d = epds_pkg::ST_RPT_WR;
			epds_pkg::ST_RPT_WR:  st_d = epds_pkg::ST_IDLE;
			default:              st_d = epds_pkg::ST_IDLE;
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		req_stall = (st_q != epds_pkg::ST_IDLE);
		res_valid = (st_q == epds_pkg::ST_FINISH);
		issue     = (st_q == epds_pkg::ST_SCAN) && (remain_q != '0);
		we        = (st_q == epds_pkg::ST_RPT_WR);
		raddr     = (st_q == epds_pkg::ST_SCAN) ? idx_q : rpt_slot;
	end

	// Result word.
	always_comb begin
		if (late_q) begin
			res.kind        = epds_pkg::KIND_WAIT;
			res.chosen_slot = '0;
			res.wait_ms     = (diff_q > epds_pkg::TIME_W'(epds_pkg::WAIT_CAP)) ?
				epds_pkg::WAIT_W'(epds_pkg::WAIT_CAP) : diff_q[epds_pkg::WAIT_W-1:0];
		end else begin
			res.kind        = epds_pkg::KIND_ISSUE;
			res.chosen_slot = 6'(best_q);
			res.wait_ms     = '0;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= epds_pkg::ST_IDLE;
			running_q   <= 1'b0;
			next_slot_q <= '0;
			valid_q     <= '0;
			live_s1     <= 1'b0;
		end else begin
			st_q    <= st_d;
			live_s1 <= issue;
			if (accept && req.operation == epds_pkg::OP_START) begin
				valid_q     <= '0;
				next_slot_q <= '0;
				running_q   <= (slot_cnt != '0);
			end else if (accept && req.operation == epds_pkg::OP_STOP) begin
				running_q <= 1'b0;
			end
			if (we) begin
				valid_q[rpt_slot] <= 1'b1;
			end
			if (st_q == epds_pkg::ST_FINISH && res_taken && !late_q) begin
				next_slot_q <= best_next;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_vld_s1 <= valid_q[raddr];
		rd_idx_s1 <= raddr;
		first_s1  <= (remain_q == slot_cnt);
		if (accept) begin
			req_q <= req;
			idx_q <= next_slot_q;
		end
		unique case (st_q)
			epds_pkg::ST_MOD: begin
				// Bring the saved slot into range by repeated subtraction.
				if (idx_ext >= slot_cnt) begin
					idx_q <= epds_pkg::SLOT_W'(idx_ext - slot_cnt);
				end else begin
					remain_q <= slot_cnt;
				end
			end
			epds_pkg::ST_SCAN: begin
				if (issue) begin
					idx_q    <= idx_next;
					remain_q <= remain_q - epds_pkg::CNT_W'(1);
				end
				// Keep the first entry with the strictly smallest due time.
				if (live_s1 && (first_s1 || cur_due < best_due_q)) begin
					best_due_q <= cur_due;
					best_q     <= rd_idx_s1;
				end
			end
			epds_pkg::ST_DIFF: begin
				diff_q <= diff_full[epds_pkg::TIME_W-1:0];
				late_q <= !diff_full[epds_pkg::TIME_W] &&
					(diff_full[epds_pkg::TIME_W-1:0] != '0);
			end
			epds_pkg::ST_RPT_DLY: begin
				streak_q <= new_streak;
				delay_q  <= delay_cap;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/earliest_due_poll_scheduler_core.sv
// A select scans as many entries as the slot count (frame_count capped at 64)
// before its result word, after repeated subtraction when the saved slot lies beyond a
// reduced slot count; the scan reads one slot entry per cycle from the single
// slot RAM read port, and a stalled result holds the input until it is taken.
// A report reads, backs off and writes its slot entry in turn; one word is worked at a time.
// Reset clears control state and the entry valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// earliest_due_poll_scheduler_core: earliest-due poll scheduler top level
// Holds the frame count register and the result register, and wraps the
// scan engine with its slot RAM.
// ----------------------------------------------------------------------------
module earliest_due_poll_scheduler_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  epds_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output epds_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [epds_pkg::FCOUNT_W-1:0]   cfg_data
);

	logic [epds_pkg::FCOUNT_W-1:0] frame_count_q;
	logic [epds_pkg::CNT_W-1:0]    slot_cnt;
	logic                          rsp_valid_q;
	epds_pkg::rsp_t                rsp_q;
	logic                          res_valid;
	epds_pkg::rsp_t                res;
	logic                          res_taken;

	// Configuration is always accepted.
	assign cfg_ready = 1'b1;

	// Slot count clamped to the store size.
	assign slot_cnt = (int'(frame_count_q) > epds_pkg::MAX_SLOTS) ?
		epds_pkg::CNT_W'(epds_pkg::MAX_SLOTS) : epds_pkg::CNT_W'(frame_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			frame_count_q <= cfg_data;
		end
	end

	epds_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.slot_cnt (slot_cnt),
		.res_valid(res_valid),
		.res      (res),
		.res_taken(res_taken)
	);

	// Result register: loads when empty or when its word leaves this cycle.
	assign res_taken = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_taken) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/core/epds_checker.sv
// ----------------------------------------------------------------------------
// epds_checker: port-level checks of the poll scheduler
// Watches the top level's ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
module epds_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  epds_pkg::req_t                  req,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  epds_pkg::rsp_t                  rsp
);

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// Only a select produces a result word.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.operation != epds_pkg::OP_SELECT
		|=> !$rose(rsp_valid))
		else $error("result word after a non-select input word");

	// A new result word appears only as the engine returns to accept input.
	a_free_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !req_stall)
		else $error("input still stalled after a result was handed over");

	// A wait result carries a wait of 1 to 1000 ms and no slot.
	a_wait_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == epds_pkg::KIND_WAIT |->
		rsp.wait_ms != '0 && rsp.wait_ms <= 10'd1000 && rsp.chosen_slot == '0)
		else $error("wait result out of range");

endmodule

bind earliest_due_poll_scheduler_core epds_checker u_epds_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the earliest-due poll scheduler core
// Drives select, report, start and stop words with random idling on both
// sides, predicts every result word from its own copy of the slot state and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import epds_pkg::*;

	// Scoreboard: tracks due times, streaks and the rotation pointer and
	// queues the result word that each accepted request word should cause.
	class poll_schedule_board;
		logic [TIME_W-1:0]   due_ms[MAX_SLOTS];
		logic [STREAK_W-1:0] streak[MAX_SLOTS];
		int unsigned         next_slot;
		bit                  running;
		logic [FCOUNT_W-1:0] frame_count;
		rsp_t                awaited_words[$];
		int                  errors;

		function new();
			clear_slots();
			running = 1'b0;
			frame_count = '0;
			errors = 0;
		endfunction

		function void clear_slots();
			for (int i = 0; i < MAX_SLOTS; i++) begin
				due_ms[i] = '0;
				streak[i] = '0;
			end
			next_slot = 0;
		endfunction

		function int pending();
			return awaited_words.size();
		endfunction

		// Applies one accepted request word; returns 1 with the predicted
		// result word when the request produces one.
		function bit note_request(input req_t r, output rsp_t res);
			int unsigned         n;
			int unsigned         s;
			int unsigned         first;
			int unsigned         best;
			int unsigned         idx;
			logic [TIME_W-1:0]   best_due;
			logic [TIME_W-1:0]   gap;
			logic [31:0]         delay;
			res = '0;
			n = (frame_count > MAX_SLOTS) ? MAX_SLOTS : frame_count;
			s = r.slot_index;
			if (r.operation == OP_START) begin
				clear_slots();
				running = (n > 0);
				return 1'b0;
			end
			if (r.operation == OP_STOP) begin
				running = 1'b0;
				return 1'b0;
			end
			if (!running || n == 0)
				return 1'b0;

			// Report: update the streak and push the due time out by the
			// backed-off period, capped.
			if (r.operation == OP_REPORT) begin
				if (s >= n)
					return 1'b0;
				if (r.succeeded)
					streak[s] = '0;
				else if (streak[s] < STREAK_CAP)
					streak[s] = streak[s] + 3'd1;
				delay = (r.period_ms == '0) ? 32'd1 : {16'd0, r.period_ms};
				delay = delay << streak[s];
				if (delay > DELAY_CAP)
					delay = DELAY_CAP;
				due_ms[s] = r.now_ms + {16'd0, delay};
				return 1'b0;
			end

			// Select: rotate from the saved slot, the first earliest due wins.
			first = next_slot % n;
			best = first;
			best_due = due_ms[first];
			for (int unsigned k = 1; k < n; k++) begin
				idx = (first + k) % n;
				if (due_ms[idx] < best_due) begin
					best = idx;
					best_due = due_ms[idx];
				end
			end
			if (best_due > r.now_ms) begin
				gap = best_due - r.now_ms;
				if (gap > WAIT_CAP)
					gap = WAIT_CAP;
				res.kind = KIND_WAIT;
				res.wait_ms = gap[WAIT_W-1:0];
			end else begin
				next_slot = (best + 1) % n;
				res.kind = KIND_ISSUE;
				res.chosen_slot = best[5:0];
			end
			awaited_words.push_back(res);
			return 1'b1;
		endfunction

		// Compares one accepted result word with the oldest prediction.
		function void check_result(input rsp_t got);
			rsp_t want;
			if (awaited_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: kind %0d slot %0d wait %0d",
						got.kind, got.chosen_slot, got.wait_ms);
				return;
			end
			want = awaited_words.pop_front();
			if (got.kind !== want.kind || got.chosen_slot !== want.chosen_slot ||
					got.wait_ms !== want.wait_ms) begin
				errors++;
				if (errors <= 10) begin
					$write("result mismatch: expected kind %0d slot %0d wait %0d, ",
						want.kind, want.chosen_slot, want.wait_ms);
					$display("got kind %0d slot %0d wait %0d",
						got.kind, got.chosen_slot, got.wait_ms);
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [FCOUNT_W-1:0] cfg_data = '0;

	poll_schedule_board sb = new();
	bit   calm = 1'b0;
	bit   pred_has;
	rsp_t pred_res;

	earliest_due_poll_scheduler_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side: random stalls except during the calm stretch.
	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99, 0) < 25);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
	end

	function automatic req_t mk(op_e op, logic [TIME_W-1:0] now, logic [5:0] slot,
			logic ok, logic [PERIOD_W-1:0] period);
		req_t r;
		r.operation = op;
		r.now_ms = now;
		r.slot_index = slot;
		r.succeeded = ok;
		r.period_ms = period;
		return r;
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	function automatic logic [PERIOD_W-1:0] rand_period();
		int unsigned roll;
		roll = $urandom_range(9, 0);
		if (roll < 7)
			return PERIOD_W'($urandom_range(200, 1));
		if (roll < 9)
			return PERIOD_W'($urandom_range(2000, 200));
		return PERIOD_W'($urandom);
	endfunction

	// Sends one request word and records its predicted result.
	task automatic send(input req_t r);
		int unsigned pause;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pred_has = sb.note_request(r, pred_res);
		if (!calm && $urandom_range(99, 0) < 25) begin
			pause = ($urandom_range(9, 0) == 0) ? $urandom_range(90, 20)
				: $urandom_range(6, 1);
			req_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
	endtask

	// Lets every outstanding word drain, then covers report and start
	// words, which leave no result behind, plus the longest select scan.
	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (160) @(posedge clk);
	endtask

	task automatic write_frame_count(input logic [FCOUNT_W-1:0] value);
		wait_quiet();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.frame_count = value;
	endtask

	initial begin
		logic [FCOUNT_W-1:0] phase_count[9];
		bit                  phase_restart[9];
		logic [TIME_W-1:0]   clock_ms;
		int unsigned         roll;
		phase_count = '{7'd1, 7'd64, 7'd127, 7'd6, 7'd2, 7'd0, 7'd65, 7'd33, 7'd5};
		phase_restart = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
		clock_ms = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no slots, then four slots with zero period, wrapping due
		// time, out-of-range reports, streak saturation, both result kinds.
		write_frame_count(7'd0);
		send(mk(OP_SELECT, '0, 6'd0, 1'b0, 16'd1));
		send(mk(OP_START, '0, 6'd0, 1'b0, 16'd1));
		write_frame_count(7'd4);
		send(mk(OP_REPORT, '0, 6'd0, 1'b1, 16'd10));
		send(mk(OP_START, '0, 6'd0, 1'b0, 16'd1));
		send(mk(OP_SELECT, '0, 6'd0, 1'b0, 16'd1));
		send(mk(OP_REPORT, '0, 6'd0, 1'b1, 16'd0));
		send(mk(OP_SELECT, '0, 6'd0, 1'b0, 16'd1));
		send(mk(OP_REPORT, 48'hFFFF_FFFF_FFFB, 6'd1, 1'b0, 16'hFFFF));
		send(mk(OP_REPORT, '0, 6'd4, 1'b1, 16'd5));
		send(mk(OP_SELECT, '0, 6'd63, 1'b1, 16'hFFFF));
		send(mk(OP_REPORT, '0, 6'd2, 1'b1, 16'hFFFF));
		repeat (6)
			send(mk(OP_REPORT, 48'd100, 6'd3, 1'b0, 16'd3));
		send(mk(OP_SELECT, 48'd1, 6'd0, 1'b0, 16'd1));
		send(mk(OP_SELECT, '0, 6'd0, 1'b0, 16'd1));
		send(mk(OP_REPORT, '0, 6'd3, 1'b1, 16'd2000));
		send(mk(OP_REPORT, '0, 6'd0, 1'b1, 16'd1500));
		send(mk(OP_SELECT, '0, 6'd0, 1'b0, 16'd1));
		send(mk(OP_STOP, '0, 6'd0, 1'b0, 16'd1));

		// Random phases: mostly select-then-report sequences on a moving
		// clock, with noise words, stops and restarts mixed in.
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 8)
				phase_count[ph] = FCOUNT_W'($urandom_range(127, 1));
			write_frame_count(phase_count[ph]);
			calm = (ph == 3 || ph == 4);
			clock_ms = clock_ms + TIME_W'($urandom_range(5000, 0));
			if (phase_restart[ph])
				send(mk(OP_START, clock_ms, 6'($urandom), 1'($urandom), rand_period()));
			for (int k = 0; k < 32; k++) begin
				roll = $urandom_range(99, 0);
				if (!sb.running && roll < 80) begin
					send(mk(OP_START, clock_ms, 6'($urandom), 1'($urandom), rand_period()));
				end else if (roll < 70) begin
					clock_ms = clock_ms + TIME_W'($urandom_range(30, 0));
					send(mk(OP_SELECT, clock_ms, 6'($urandom), 1'($urandom), 16'($urandom)));
					if (pred_has && pred_res.kind == KIND_ISSUE &&
							$urandom_range(9, 0) != 0) begin
						clock_ms = clock_ms + TIME_W'($urandom_range(20, 0));
						send(mk(OP_REPORT, clock_ms, pred_res.chosen_slot,
							$urandom_range(9, 0) < 6, rand_period()));
					end else if (pred_has && pred_res.kind == KIND_WAIT) begin
						clock_ms = clock_ms + TIME_W'(pred_res.wait_ms)
							- TIME_W'($urandom_range(1, 0));
					end
				end else if (roll < 80) begin
					send(mk(OP_REPORT, clock_ms, 6'($urandom), 1'($urandom), 16'($urandom)));
				end else if (roll < 88) begin
					send(mk(OP_SELECT, rand_time(), 6'($urandom), 1'($urandom), 16'($urandom)));
				end else if (roll < 94) begin
					send(mk(OP_START, clock_ms, 6'($urandom), 1'($urandom), 16'($urandom)));
				end else if (roll < 97) begin
					send(mk(OP_STOP, rand_time(), 6'($urandom), 1'($urandom), 16'($urandom)));
				end else begin
					send(mk(op_e'(2'($urandom)), rand_time(), 6'($urandom), 1'($urandom),
						16'($urandom)));
				end
			end
		end
		calm = 1'b0;

		wait_quiet();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#8_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
